// ===== sv/knb_pkg.sv =====
// ----------------------------------------------------------------------------
// knb_pkg
// Shared types, codes and constants of the per-site noise generator bank.
// ----------------------------------------------------------------------------
package knb_pkg;

	// command codes
	localparam logic [1:0] CMD_SEED     = 2'd0;
	localparam logic [1:0] CMD_DISCRETE = 2'd1;
	localparam logic [1:0] CMD_UNIFORM  = 2'd2;

	// register indexes
	localparam logic REG_MASTER_SEED   = 1'b0;
	localparam logic REG_DEVIATE_COUNT = 1'b1;

	localparam logic [30:0] MASTER_SEED_RESET   = 31'd0;
	localparam logic [3:0]  DEVIATE_COUNT_RESET = 4'd10;

	// generator constants
	localparam logic [31:0] DEFAULT_SEED = 32'd13;
	localparam logic [31:0] SEED_Y       = 32'd12953;
	localparam logic [31:0] SEED_Z       = 32'd712357;
	localparam logic [31:0] SEED_W       = 32'd22383979;
	localparam logic [16:0] LCG_MUL      = 17'd69069;
	localparam logic [31:0] LCG_ADD      = 32'd1234567;
	localparam logic [16:0] MWCH_MUL     = 17'd36969;
	localparam logic [16:0] MWCL_MUL     = 17'd18000;

	// operations of the shared step unit
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_LCG,
		OP_MWCH,
		OP_MWCL
	} knb_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ,
		ST_LOAD,
		ST_LCG,
		ST_MWCH,
		ST_MWCL,
		ST_OUT,
		ST_WRITE,
		ST_EMIT
	} knb_state_t;

	// one generator state, as held per site
	typedef struct packed {
		logic [31:0] lcg;
		logic [31:0] xsh;
		logic [31:0] mwch;
		logic [31:0] mwcl;
	} knb_kiss_t;

	// control from the sequencer to the step unit
	typedef struct packed {
		knb_op_t   op;
		knb_kiss_t ld;
	} knb_unit_ctl_t;

	// three-bit code to Q2.14 deviate
	function automatic logic signed [15:0] knb_dev_value(input logic [2:0] code);
		logic signed [15:0] v;
		case (code)
			3'd0: v = -16'sd30274;
			3'd1: v = -16'sd12540;
			3'd6: v = 16'sd12540;
			3'd7: v = 16'sd30274;
			default: v = 16'sd0;
		endcase
		return v;
	endfunction

endpackage

// ===== sv/knb_ram.sv =====
// ----------------------------------------------------------------------------
// knb_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module knb_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/knb_kiss_unit.sv =====
// ----------------------------------------------------------------------------
// knb_kiss_unit
// Generator state register with one shared constant multiply-add, stepped
// through the three product terms of a generator step one per cycle.
// ----------------------------------------------------------------------------
module knb_kiss_unit
	import knb_pkg::*;
(
	input  logic          clk,
	input  knb_unit_ctl_t ctl,
	output knb_kiss_t     st,
	output logic [31:0]   word
);

	knb_kiss_t   st_q;
	logic [31:0] mul_a;
	logic [16:0] mul_k;
	logic [31:0] mul_c;
	logic [48:0] prod;
	logic [31:0] mac;
	logic [31:0] xs_a;
	logic [31:0] xs_b;
	logic [31:0] xs_next;

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = st_q.lcg;
		mul_k = LCG_MUL;
		mul_c = LCG_ADD;
		case (ctl.op)
			OP_MWCH: begin
				mul_a = {16'd0, st_q.mwch[15:0]};
				mul_k = MWCH_MUL;
				mul_c = {16'd0, st_q.mwch[31:16]};
			end
			OP_MWCL: begin
				mul_a = {16'd0, st_q.mwcl[15:0]};
				mul_k = MWCL_MUL;
				mul_c = {16'd0, st_q.mwcl[31:16]};
			end
			default: begin
				mul_a = st_q.lcg;
				mul_k = LCG_MUL;
				mul_c = LCG_ADD;
			end
		endcase
	end

	assign prod = mul_a * mul_k;
	assign mac  = prod[31:0] + mul_c;

	assign xs_a    = st_q.xsh ^ (st_q.xsh << 17);
	assign xs_b    = xs_a ^ (xs_a >> 13);
	assign xs_next = xs_b ^ (xs_b << 5);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_LOAD: st_q <= ctl.ld;
			OP_LCG:  st_q.lcg <= mac;
			OP_MWCH: st_q.mwch <= mac;
			OP_MWCL: begin
				st_q.mwcl <= mac;
				st_q.xsh  <= xs_next;
			end
			default: st_q <= st_q;
		endcase
	end

	assign st   = st_q;
	assign word = st_q.xsh + (st_q.lcg ^ ({st_q.mwch[15:0], 16'd0} + st_q.mwcl));

endmodule

// ===== sv/per_site_kiss_noise_bank.sv =====
// ----------------------------------------------------------------------------
// per_site_kiss_noise_bank
// Bank of combined generators, one four-word state per site in a RAM,
// with seed, discrete deviate and raw uniform draws.
// ----------------------------------------------------------------------------
//  channel   signals                                        dir
//  cmd       cmd_valid cmd_stall command site gx gy gz      in
//  res       res_valid res_stall uniform_word deviate_code
//            deviate_value last                             out
//  apb       psel penable pwrite paddr pwdata prdata pready  in/out
//
//  seed request: seed load, four generator steps on the shared multiply-add,
//  then one RAM write; no result
//  draw request: RAM read, load, one step, write, then one result per cycle
//  while res_stall is low; a step runs the LCG, MWCH and MWCL terms in turn
//  one request at a time; cmd_stall is high from acceptance until the last
//  result is taken or the seed is written; ignored requests are dropped
//  in the idle state; reset clears control and configuration registers
//  only; site state is undefined until that site is seeded
// ----------------------------------------------------------------------------
module per_site_kiss_noise_bank
	import knb_pkg::*;
#(
	parameter int SITES        = 4096,
	parameter int MAX_DEVIATES = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic [11:0]        site,
	input  logic [15:0]        gx,
	input  logic [15:0]        gy,
	input  logic [15:0]        gz,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [31:0]        uniform_word,
	output logic [2:0]         deviate_code,
	output logic signed [15:0] deviate_value,
	output logic               last,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW = (SITES > 1) ? $clog2(SITES) : 1;
	localparam int BW = 3 * MAX_DEVIATES;
	localparam logic [3:0] MAX_N = 4'(MAX_DEVIATES);

	knb_state_t    state_q, state_d;
	knb_unit_ctl_t unit_ctl;
	knb_kiss_t     unit_st;
	knb_kiss_t     ram_rdata;
	knb_kiss_t     ram_wdata;
	knb_kiss_t     seed_vec;
	logic [31:0]   unit_word;
	logic          ram_we;

	logic [30:0]   master_seed_q;
	logic [3:0]    deviate_count_q;
	logic          cfg_write;

	logic [1:0]    cmd_q;
	logic [AW-1:0] site_q;
	logic [1:0]    iter_q;
	logic [31:0]   collect_q [4];
	logic [31:0]   word_q;
	logic [BW-1:0] bits_q;
	logic [3:0]    rem_q;

	logic          cmd_acc;
	logic          res_acc;
	logic          cmd_take;
	logic [31:0]   site_ext;
	logic [31:0]   seed_base;
	logic [3:0]    dev_n;

	// configuration registers
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			master_seed_q   <= MASTER_SEED_RESET;
			deviate_count_q <= DEVIATE_COUNT_RESET;
		end else if (cfg_write) begin
			if (paddr[2] == REG_MASTER_SEED) begin
				master_seed_q <= pwdata[30:0];
			end else begin
				deviate_count_q <= pwdata[3:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_DEVIATE_COUNT) begin
			prdata = {28'd0, deviate_count_q};
		end else begin
			prdata = {1'b0, master_seed_q};
		end
	end

	// request decode
	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign res_acc  = res_valid && !res_stall;
	assign site_ext = {20'd0, site};
	assign cmd_take = cmd_acc &&
		(command == CMD_SEED || command == CMD_DISCRETE || command == CMD_UNIFORM) &&
		(site_ext < 32'(SITES));

	assign seed_base     = (master_seed_q != 31'd0) ? {1'b0, master_seed_q} : DEFAULT_SEED;
	assign seed_vec.lcg  = seed_base + {16'd0, gx};
	assign seed_vec.xsh  = SEED_Y + {16'd0, gy};
	assign seed_vec.mwch = SEED_Z + {16'd0, gz};
	assign seed_vec.mwcl = SEED_W;

	always_comb begin
		if (deviate_count_q == 4'd0) begin
			dev_n = 4'd1;
		end else if (deviate_count_q > MAX_N) begin
			dev_n = MAX_N;
		end else begin
			dev_n = deviate_count_q;
		end
	end

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_take) begin
					state_d = (command == CMD_SEED) ? ST_LCG : ST_READ;
				end
			end
			ST_READ:  state_d = ST_LOAD;
			ST_LOAD:  state_d = ST_LCG;
			ST_LCG:   state_d = ST_MWCH;
			ST_MWCH:  state_d = ST_MWCL;
			ST_MWCL:  state_d = ST_OUT;
			ST_OUT: begin
				if (cmd_q == CMD_SEED && iter_q != 2'd3) begin
					state_d = ST_LCG;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = (cmd_q == CMD_SEED) ? ST_IDLE : ST_EMIT;
			ST_EMIT: begin
				if (res_acc && last) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		unit_ctl.op = OP_NONE;
		unit_ctl.ld = ram_rdata;
		ram_we      = 1'b0;
		cmd_stall   = 1'b1;
		res_valid   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd_stall = 1'b0;
				if (cmd_take && command == CMD_SEED) begin
					unit_ctl.op = OP_LOAD;
					unit_ctl.ld = seed_vec;
				end
			end
			ST_LOAD:  unit_ctl.op = OP_LOAD;
			ST_LCG:   unit_ctl.op = OP_LCG;
			ST_MWCH:  unit_ctl.op = OP_MWCH;
			ST_MWCL:  unit_ctl.op = OP_MWCL;
			ST_WRITE: ram_we = 1'b1;
			ST_EMIT:  res_valid = 1'b1;
			default:  unit_ctl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q   <= CMD_SEED;
			iter_q  <= 2'd0;
			rem_q   <= 4'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd_take) begin
				cmd_q  <= command;
				iter_q <= 2'd0;
			end else if (state_q == ST_OUT) begin
				iter_q <= iter_q + 2'd1;
				if (cmd_q == CMD_DISCRETE) begin
					rem_q <= dev_n - 4'd1;
				end else begin
					rem_q <= 4'd0;
				end
			end else if (state_q == ST_EMIT && res_acc && !last) begin
				rem_q <= rem_q - 4'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_take) begin
			site_q <= site_ext[AW-1:0];
		end
		if (state_q == ST_OUT) begin
			collect_q[iter_q] <= unit_word;
			word_q            <= unit_word;
			bits_q            <= unit_word[2 +: BW];
		end else if (state_q == ST_EMIT && res_acc) begin
			bits_q <= bits_q >> 3;
		end
	end

	assign ram_wdata = (cmd_q == CMD_SEED) ?
		{collect_q[0], collect_q[1], collect_q[2], collect_q[3]} : unit_st;

	knb_ram #(
		.WIDTH ($bits(knb_kiss_t)),
		.DEPTH (SITES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (site_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	knb_kiss_unit u_unit (
		.clk  (clk),
		.ctl  (unit_ctl),
		.st   (unit_st),
		.word (unit_word)
	);

	// result payload; a uniform draw carries a zero deviate
	assign uniform_word  = word_q;
	assign deviate_code  = (cmd_q == CMD_DISCRETE) ? bits_q[2:0] : 3'd0;
	assign deviate_value = (cmd_q == CMD_DISCRETE) ? knb_dev_value(deviate_code) : 16'sd0;
	assign last          = (rem_q == 4'd0);

	// a uniform draw gives exactly one result
	a_uniform_single: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && cmd_q == CMD_UNIFORM) |-> last)
		else $error("uniform draw result not marked last");

	// no new request is taken while results are pending
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> cmd_stall)
		else $error("request taken while results pending");

	// the final result closes the draw
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_stall && last) |=> (!res_valid && !cmd_stall))
		else $error("draw continued after its last result");

	// remaining count never exceeds the clamp
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (rem_q < MAX_N))
		else $error("deviate count beyond limit");

	// seeding never presents a result
	a_seed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q == CMD_SEED && state_q != ST_IDLE) |-> !res_valid)
		else $error("seed request produced a result");

endmodule
